// ===== rtl/alpn_pkg.sv =====
// ----------------------------------------------------------------------------
// alpn_pkg
// Types, codes and name tables for the ALPN protocol list selector.
// ----------------------------------------------------------------------------
package alpn_pkg;

	// Longest list that is parsed; bytes beyond it are errors
	localparam logic [15:0] MAX_LIST_BYTES = 16'd65535;

	// Entry lengths of the two recognized protocol names
	localparam logic [7:0] H2_NAME_LEN   = 8'd2;
	localparam logic [7:0] HTTP_NAME_LEN = 8'd8;

	// Lengths reported with a verdict
	localparam logic [3:0] H2_CHOSEN_LEN   = 4'd2;
	localparam logic [3:0] HTTP_CHOSEN_LEN = 4'd8;

	// Verdict codes
	typedef enum logic [1:0] {
		VERDICT_FATAL = 2'd0,
		VERDICT_H2    = 2'd1,
		VERDICT_HTTP  = 2'd2
	} verdict_t;

	// Characters of "h2"
	function automatic logic [7:0] h2_char(input logic idx);
		logic [7:0] c;
		unique case (idx)
			1'b0:    c = 8'h68;
			default: c = 8'h32;
		endcase
		return c;
	endfunction

	// Characters of "http/1.1"
	function automatic logic [7:0] http_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h68;
			3'd1:    c = 8'h74;
			3'd2:    c = 8'h74;
			3'd3:    c = 8'h70;
			3'd4:    c = 8'h2f;
			3'd5:    c = 8'h31;
			3'd6:    c = 8'h2e;
			default: c = 8'h31;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/alpn_list_protocol_selector_core.sv =====
// ----------------------------------------------------------------------------
// alpn_list_protocol_selector_core
// Parses a length-prefixed ALPN protocol list one byte per transaction and
// returns one verdict (h2, http/1.1 or fatal) when the list ends.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | list_byte, has_byte, end_of_list
//  output  | out_valid / out_ready| verdict, chosen_offset, chosen_length
//
// One input transaction per cycle while the input register does not stall; the
// verdict is presented once the end-of-list transaction has passed the input
// register and then the result register.
// The parse state is updated once per advancing cycle by the logic behind the input
// register; only the end-of-list transaction writes the result register.
// The input register stalls only when it holds an end-of-list transaction
// and the result register is still full and not being taken.
// Reset clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module alpn_list_protocol_selector_core
	import alpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  list_byte,
	input  logic        has_byte,
	input  logic        end_of_list,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [15:0] chosen_offset,
	output logic [3:0]  chosen_length
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	// Parse state
	logic [15:0] byte_pos_q;
	logic [7:0]  entry_rem_q;
	logic [7:0]  entry_len_q;
	logic [15:0] entry_start_q;
	logic        h2_match_q;
	logic        http_match_q;
	logic        h2_found_q;
	logic [15:0] h2_offset_q;
	logic        http_found_q;
	logic [15:0] http_offset_q;
	logic        error_q;

	// Result register
	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [15:0] offset_q;
	logic [3:0]  length_q;

	// Next state
	logic [15:0] byte_pos_d;
	logic [7:0]  entry_rem_d;
	logic [7:0]  entry_len_d;
	logic [15:0] entry_start_d;
	logic        h2_match_d;
	logic        http_match_d;
	logic        h2_found_d;
	logic [15:0] h2_offset_d;
	logic        http_found_d;
	logic [15:0] http_offset_d;
	logic        error_d;
	logic        error_final;
	logic [7:0]  idx;

	verdict_t    verdict_d;
	logic [15:0] offset_d;
	logic [3:0]  length_d;

	logic out_free;
	logic advance;

	// Handshake control
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= list_byte;
			has_s1  <= has_byte;
			last_s1 <= end_of_list;
		end
	end

	// Per-byte parse step
	always_comb begin
		byte_pos_d    = byte_pos_q;
		entry_rem_d   = entry_rem_q;
		entry_len_d   = entry_len_q;
		entry_start_d = entry_start_q;
		h2_match_d    = h2_match_q;
		http_match_d  = http_match_q;
		h2_found_d    = h2_found_q;
		h2_offset_d   = h2_offset_q;
		http_found_d  = http_found_q;
		http_offset_d = http_offset_q;
		error_d       = error_q;
		idx           = entry_len_q - entry_rem_q;

		if (has_s1) begin
			if (byte_pos_q >= MAX_LIST_BYTES) begin
				error_d = 1'b1;
			end else begin
				if (entry_rem_q == 8'd0) begin
					// length byte opens a new entry
					if (byte_s1 == 8'd0) begin
						error_d = 1'b1;
					end else begin
						entry_len_d   = byte_s1;
						entry_rem_d   = byte_s1;
						entry_start_d = byte_pos_q + 16'd1;
						h2_match_d    = (byte_s1 == H2_NAME_LEN);
						http_match_d  = (byte_s1 == HTTP_NAME_LEN);
					end
				end else begin
					// name byte: compare against both names
					if (h2_match_q && (idx >= 8'd2 || h2_char(idx[0]) != byte_s1))
						h2_match_d = 1'b0;
					if (http_match_q && (idx >= 8'd8 || http_char(idx[2:0]) != byte_s1))
						http_match_d = 1'b0;
					entry_rem_d = entry_rem_q - 8'd1;
					if (entry_rem_d == 8'd0 && !error_q) begin
						if (h2_match_d && !h2_found_q) begin
							h2_found_d  = 1'b1;
							h2_offset_d = entry_start_q;
						end
						if (http_match_d && !http_found_q) begin
							http_found_d  = 1'b1;
							http_offset_d = entry_start_q;
						end
					end
				end
				byte_pos_d = byte_pos_q + 16'd1;
			end
		end
	end

	// Verdict at end of list; h2 wins if found, http/1.1 only without an error; an unfinished entry counts as an error
	always_comb begin
		error_final = error_d || (entry_rem_d != 8'd0);
		verdict_d   = VERDICT_FATAL;
		offset_d    = 16'd0;
		length_d    = 4'd0;
		priority if (h2_found_d) begin
			verdict_d = VERDICT_H2;
			offset_d  = h2_offset_d;
			length_d  = H2_CHOSEN_LEN;
		end else if (!error_final && http_found_d) begin
			verdict_d = VERDICT_HTTP;
			offset_d  = http_offset_d;
			length_d  = HTTP_CHOSEN_LEN;
		end
	end

	// Parse state registers; cleared after every verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q    <= '0;
			entry_rem_q   <= '0;
			entry_len_q   <= '0;
			entry_start_q <= '0;
			h2_match_q    <= 1'b0;
			http_match_q  <= 1'b0;
			h2_found_q    <= 1'b0;
			h2_offset_q   <= '0;
			http_found_q  <= 1'b0;
			http_offset_q <= '0;
			error_q       <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				byte_pos_q    <= '0;
				entry_rem_q   <= '0;
				entry_len_q   <= '0;
				entry_start_q <= '0;
				h2_match_q    <= 1'b0;
				http_match_q  <= 1'b0;
				h2_found_q    <= 1'b0;
				h2_offset_q   <= '0;
				http_found_q  <= 1'b0;
				http_offset_q <= '0;
				error_q       <= 1'b0;
			end else begin
				byte_pos_q    <= byte_pos_d;
				entry_rem_q   <= entry_rem_d;
				entry_len_q   <= entry_len_d;
				entry_start_q <= entry_start_d;
				h2_match_q    <= h2_match_d;
				http_match_q  <= http_match_d;
				h2_found_q    <= h2_found_d;
				h2_offset_q   <= h2_offset_d;
				http_found_q  <= http_found_d;
				http_offset_q <= http_offset_d;
				error_q       <= error_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict_d;
			offset_q  <= offset_d;
			length_q  <= length_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign chosen_offset = offset_q;
	assign chosen_length = length_q;

	// Checks
	a_fatal_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q == VERDICT_FATAL |-> offset_q == 16'd0 && length_q == 4'd0)
		else $error("fatal verdict carries a protocol");

	a_h2_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q == VERDICT_H2 |-> length_q == H2_CHOSEN_LEN)
		else $error("h2 verdict with wrong length");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full result register");

	a_list_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> byte_pos_q == 16'd0 && entry_rem_q == 8'd0 && !error_q)
		else $error("parse state not cleared after verdict");

endmodule
